[rtl/bop_pkg.sv]
package bop_pkg;

    localparam int unsigned BOP_FACTOR_W = 32;
    localparam int unsigned BOP_LO_W     = 32;
    // high slice of a price, sized for the widest price the block supports
    localparam int unsigned BOP_HI_W     = 16;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned STEP_CFG_W   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DOWN_RATIO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_PROB_UP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_PROB_DOWN = 3'd4;

    typedef struct packed {
        logic [31:0] spot;
        logic [31:0] strike;
        logic        option_kind;
    } t_bop_in;

    typedef struct packed {
        logic [31:0] option_value;
        logic        saturated;
    } t_bop_out;

endpackage

[rtl/bop_ram.sv]
module bop_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bop_scale.sv]
// Truncating product of a price and a 32-bit factor, shifted right by 30 or 32.
// Two stages: partial products, then align and add.
module bop_scale #(
    parameter int unsigned PRICE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic [PRICE_WIDTH-1:0] i_price,
    input  logic [31:0]            i_factor,
    input  logic                   i_q30,
    output logic [PRICE_WIDTH+1:0] o_result
);

    import bop_pkg::*;

    logic [63:0]                     w_price64;
    logic [BOP_LO_W-1:0]             w_lo;
    logic [BOP_HI_W-1:0]             w_hi;
    logic [BOP_LO_W+BOP_FACTOR_W-1:0] r_lo_prod;
    logic [BOP_HI_W+BOP_FACTOR_W-1:0] r_hi_prod;
    logic                            r_q30;
    logic [BOP_HI_W+BOP_FACTOR_W+1:0] w_sum;
    logic [PRICE_WIDTH+1:0]          r_result;

    assign w_price64 = 64'(i_price);
    assign w_lo      = w_price64[BOP_LO_W-1:0];
    assign w_hi      = w_price64[BOP_LO_W+BOP_HI_W-1:BOP_LO_W];

    always_ff @(posedge i_clk) begin
        r_lo_prod <= w_lo * i_factor;
        r_hi_prod <= w_hi * i_factor;
        r_q30     <= i_q30;
        r_result  <= w_sum[PRICE_WIDTH+1:0];
    end

    // high partial product sits 2^32 above the low one
    always_comb begin
        if (r_q30) begin
            w_sum = {r_hi_prod, 2'b00}
                  + (BOP_HI_W+BOP_FACTOR_W+2)'(r_lo_prod[63:30]);
        end else begin
            w_sum = (BOP_HI_W+BOP_FACTOR_W+2)'(r_hi_prod)
                  + (BOP_HI_W+BOP_FACTOR_W+2)'(r_lo_prod[63:32]);
        end
    end

    assign o_result = r_result;

endmodule

[rtl/binomial_option_pricer_top.sv]
// Binomial-tree (Cox-Ross-Rubinstein) pricer for European calls and puts.
// Configuration channel (i_cfg_*): index 0 step count, 1 down factor (Q2.30),
// 2 up/down ratio (Q2.30), 3 discounted up probability (Q0.32), 4 discounted
// down probability (Q0.32). Writes are always taken; other indexes are dropped.
// Input channel (i_in_*): one request carries spot, strike (Q16.16) and kind.
// Output channel (o_out_*): one result per request, Q16.16 value plus a flag
// that marks any intermediate price that clipped at full scale.
// One request is worked at a time; the node row lives in one simple dual-port
// RAM of MAX_STEPS+1 entries. With n steps the spot is multiplied n times by
// the down factor, one multiply at a time, and each terminal node waits for
// its own multiply by the up/down ratio; the backward fold then works one node per
// cycle, set by the single RAM read port, pausing at each level to prime the
// read and drain the multipliers.
// The finished value waits in an output register; the next request is taken
// while it waits, and a second finished value holds until the first is taken.
// Reset is synchronous: control and configuration registers return to their defaults, the block idles.
// The RAM needs no clearing: each entry is written before it is read.
module binomial_option_pricer_top #(
    parameter int unsigned MAX_STEPS   = 1023,
    parameter int unsigned PRICE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bop_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bop_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bop_pkg::t_bop_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bop_pkg::t_bop_out                   o_out_data
);

    import bop_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
    localparam int unsigned PW    = PRICE_WIDTH;
    localparam logic [63:0] PRICE_MAX64 = (64'd1 << PRICE_WIDTH) - 64'd1;
    localparam logic [63:0] OUT_MAX64   = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOWN,
        S_TERM,
        S_FOLD,
        S_ROOT_RD,
        S_ROOT
    } t_state;

    // configuration registers
    logic [STEP_CFG_W-1:0] r_step_count;
    logic [31:0]           r_down_factor;
    logic [31:0]           r_up_down_ratio;
    logic [31:0]           r_disc_prob_up;
    logic [31:0]           r_disc_prob_down;

    // request state
    t_state          r_state;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_level;
    logic [CNT_W-1:0] r_rd_addr;
    logic [CNT_W-1:0] r_rd_addr_q;
    logic [CNT_W-1:0] r_waddr0;
    logic [CNT_W-1:0] r_waddr1;
    logic             r_issuing;
    logic             r_rd_valid;
    logic [1:0]       r_mpipe;
    logic [PW-1:0]    r_price;
    logic [PW-1:0]    r_prev;
    logic [31:0]      r_strike;
    logic             r_is_call;
    logic             r_ovf;
    logic             r_out_valid;
    t_bop_out         r_out;

    logic [CNT_W-1:0] w_n;
    logic             w_accept;
    logic             w_launch;
    logic [PW-1:0]    w_a_price;
    logic [31:0]      w_a_factor;
    logic             w_a_q30;
    logic [PW+1:0]    w_a_res;
    logic [PW+1:0]    w_b_res;
    logic             w_a_over;
    logic [PW-1:0]    w_a_clip;
    logic [PW:0]      w_fold_sum;
    logic [PW-1:0]    w_fold_val;
    logic             w_spot_over;
    logic [PW-1:0]    w_spot_clip;
    logic [63:0]      w_price64;
    logic [63:0]      w_strike64;
    logic [63:0]      w_pay_raw;
    logic             w_pay_over;
    logic [PW-1:0]    w_pay_val;
    logic [63:0]      w_root64;
    logic             w_root_over;
    logic             w_wr_en;
    logic [CNT_W-1:0] w_wr_addr;
    logic [PW-1:0]    w_wr_data;
    logic             w_rd_en;
    logic [CNT_W-1:0] w_rd_addr;
    logic [PW-1:0]    w_rd_data;
    logic             w_out_free;
    logic             w_term_wr;
    logic             w_fold_idle;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // clamp the step count to MAX_STEPS, the last RAM entry
    always_comb begin
        if (32'(r_step_count) > 32'(MAX_STEPS)) begin
            w_n = CNT_W'(MAX_STEPS);
        end else begin
            w_n = CNT_W'(r_step_count);
        end
    end

    assign w_spot_over = 64'(i_in_data.spot) > PRICE_MAX64;
    assign w_spot_clip = w_spot_over ? '1 : PW'(i_in_data.spot);

    // payoff of the current terminal price, clipped at full scale
    assign w_price64  = 64'(r_price);
    assign w_strike64 = 64'(r_strike);
    always_comb begin
        if (r_is_call) begin
            w_pay_raw = (w_price64 > w_strike64) ? (w_price64 - w_strike64) : 64'd0;
        end else begin
            w_pay_raw = (w_strike64 > w_price64) ? (w_strike64 - w_price64) : 64'd0;
        end
    end
    assign w_pay_over = w_pay_raw > PRICE_MAX64;
    assign w_pay_val  = w_pay_over ? '1 : PW'(w_pay_raw);

    // multiplier A serves the spot walk, the u/d steps across the terminal nodes and the up branch of the fold
    always_comb begin
        unique case (r_state)
            S_FOLD: begin
                w_a_price  = w_rd_data;
                w_a_factor = r_disc_prob_up;
                w_a_q30    = 1'b0;
            end
            S_TERM: begin
                w_a_price  = r_price;
                w_a_factor = r_up_down_ratio;
                w_a_q30    = 1'b1;
            end
            default: begin
                w_a_price  = r_price;
                w_a_factor = r_down_factor;
                w_a_q30    = 1'b1;
            end
        endcase
    end

    assign w_a_over   = |w_a_res[PW+1:PW];
    assign w_a_clip   = w_a_over ? '1 : w_a_res[PW-1:0];
    assign w_fold_sum = {1'b0, w_a_res[PW-1:0]} + {1'b0, w_b_res[PW-1:0]};
    assign w_fold_val = w_fold_sum[PW] ? '1 : w_fold_sum[PW-1:0];

    assign w_term_wr   = (r_state == S_TERM) && (r_mpipe == 2'b00);
    assign w_fold_idle = !r_issuing && !r_rd_valid && (r_mpipe == 2'b00);

    // one multiply in flight during the spot walk; one node a cycle in the fold
    assign w_launch = ((r_state == S_DOWN) && (r_mpipe == 2'b00) && (r_cnt != r_n))
                   || (w_term_wr && (r_cnt != r_n))
                   || ((r_state == S_FOLD) && r_rd_valid && (r_rd_addr_q != '0));

    always_comb begin
        if (r_state == S_FOLD) begin
            w_wr_en   = r_mpipe[1];
            w_wr_addr = r_waddr1;
            w_wr_data = w_fold_val;
        end else begin
            w_wr_en   = w_term_wr;
            w_wr_addr = r_cnt;
            w_wr_data = w_pay_val;
        end
    end

    assign w_rd_en   = ((r_state == S_FOLD) && r_issuing) || (r_state == S_ROOT_RD);
    assign w_rd_addr = (r_state == S_FOLD) ? r_rd_addr : '0;

    assign w_root64    = 64'(w_rd_data);
    assign w_root_over = w_root64 > OUT_MAX64;

    bop_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_STEPS + 1)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bop_scale #(
        .PRICE_WIDTH (PW)
    ) u_scale_a (
        .i_clk    (i_clk),
        .i_price  (w_a_price),
        .i_factor (w_a_factor),
        .i_q30    (w_a_q30),
        .o_result (w_a_res)
    );

    bop_scale #(
        .PRICE_WIDTH (PW)
    ) u_scale_b (
        .i_clk    (i_clk),
        .i_price  (r_prev),
        .i_factor (r_disc_prob_down),
        .i_q30    (1'b0),
        .o_result (w_b_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count     <= STEP_CFG_W'(1);
            r_down_factor    <= 32'd1073741824;
            r_up_down_ratio  <= 32'd1073741824;
            r_disc_prob_up   <= 32'd2147483648;
            r_disc_prob_down <= 32'd2147483648;
            r_state          <= S_IDLE;
            r_issuing        <= 1'b0;
            r_rd_valid       <= 1'b0;
            r_mpipe          <= 2'b00;
            r_ovf            <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            // configuration writes; unknown indexes are dropped
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEP_COUNT:     r_step_count     <= i_cfg_data[STEP_CFG_W-1:0];
                    CFG_DOWN_FACTOR:    r_down_factor    <= i_cfg_data;
                    CFG_UP_DOWN_RATIO:  r_up_down_ratio  <= i_cfg_data;
                    CFG_DISC_PROB_UP:   r_disc_prob_up   <= i_cfg_data;
                    CFG_DISC_PROB_DOWN: r_disc_prob_down <= i_cfg_data;
                    default: ;
                endcase
            end

            // multiplier tracking and fold address pipeline
            r_mpipe    <= {r_mpipe[0], w_launch};
            r_rd_valid <= w_rd_en && (r_state == S_FOLD);
            r_rd_addr_q <= r_rd_addr;
            if (w_launch) begin
                r_waddr0 <= r_rd_addr_q - CNT_W'(1);
            end
            r_waddr1 <= r_waddr0;
            if (r_rd_valid) begin
                r_prev <= w_rd_data;
            end

            // drop the held result once it is taken; S_ROOT refills the slot itself
            if (r_out_valid && i_out_ready && (r_state != S_ROOT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_price   <= w_spot_clip;
                        r_strike  <= i_in_data.strike;
                        r_is_call <= i_in_data.option_kind;
                        r_ovf     <= w_spot_over;
                        r_n       <= w_n;
                        r_cnt     <= '0;
                        r_state   <= S_DOWN;
                    end
                end
                S_DOWN: begin
                    // spot * d^n, one truncating multiply at a time
                    if (r_mpipe[1]) begin
                        r_price <= w_a_clip;
                        r_ovf   <= r_ovf | w_a_over;
                        r_cnt   <= r_cnt + CNT_W'(1);
                    end else if ((r_mpipe == 2'b00) && (r_cnt == r_n)) begin
                        r_cnt   <= '0;
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    // write the payoff, then advance the price by u/d
                    if (r_mpipe[1]) begin
                        r_price <= w_a_clip;
                        r_ovf   <= r_ovf | w_a_over;
                        r_cnt   <= r_cnt + CNT_W'(1);
                    end else if (w_term_wr) begin
                        r_ovf <= r_ovf | w_pay_over;
                        if (r_cnt == r_n) begin
                            r_level   <= r_n;
                            r_rd_addr <= '0;
                            if (r_n == '0) begin
                                r_state <= S_ROOT_RD;
                            end else begin
                                r_issuing <= 1'b1;
                                r_state   <= S_FOLD;
                            end
                        end
                    end
                end
                S_FOLD: begin
                    if (r_issuing) begin
                        if (r_rd_addr == r_level) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_rd_addr <= r_rd_addr + CNT_W'(1);
                        end
                    end
                    if (r_mpipe[1]) begin
                        r_ovf <= r_ovf | w_fold_sum[PW];
                    end
                    // next level only after the last node of this one is written
                    if (w_fold_idle) begin
                        if (r_level == CNT_W'(1)) begin
                            r_state <= S_ROOT_RD;
                        end else begin
                            r_level   <= r_level - CNT_W'(1);
                            r_rd_addr <= '0;
                            r_issuing <= 1'b1;
                        end
                    end
                end
                S_ROOT_RD: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    // hold the root in the RAM read register until the slot frees
                    if (w_out_free) begin
                        r_out.option_value <= w_root_over ? 32'hFFFF_FFFF : 32'(w_root64);
                        r_out.saturated    <= r_ovf | w_root_over;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // No multiply may be in flight once the block reports idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_mpipe == 2'b00))
        else $error("multiplier busy while idle");

    // The fold reads ahead of its writes; they never meet on one entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_rd_en) |-> (w_wr_addr != w_rd_addr))
        else $error("row RAM read and write collide");

    // A fold write stays inside the level being reduced.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FOLD) && r_mpipe[1]) |-> (r_waddr1 < r_level))
        else $error("fold write beyond current level");

    // An accepted request starts the spot walk.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DOWN))
        else $error("request accepted without starting");

endmodule
